>>> sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the station/BSSID pair table.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int TableDepth  = 64;
    localparam int IdxW        = $clog2(TableDepth);
    localparam int CntW        = $clog2(TableDepth + 1);
    localparam logic [11:0] MinHeaderLen = 12'd24;
    localparam int GroupBit    = 40;

    typedef enum logic [1:0] {
        FN_OBSERVE = 2'd0,
        FN_READ    = 2'd1,
        FN_CLEAR   = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_NOT_DATA  = 4'd0,
        ST_BAD_DS    = 4'd1,
        ST_DROPPED   = 4'd2,
        ST_UPDATED   = 4'd3,
        ST_APPENDED  = 4'd4,
        ST_REPLACED  = 4'd5,
        ST_READ_OK   = 4'd6,
        ST_READ_OOR  = 4'd7,
        ST_CLEARED   = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OLD,
        S_WRITE,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [47:0] sta;
        logic [47:0] ap;
        logic [7:0]  sig;
        logic [3:0]  chan;
        logic [31:0] seen;
        logic [31:0] frames;
    } t_entry;

    localparam int InW  = 2 + 1 + 12 + 8 + 48 + 48 + 8 + 4 + 32 + 6;
    localparam int InBW = ((InW + 7) / 8) * 8;
    localparam int OutW  = 4 + 6 + 7 + $bits(t_entry);
    localparam int OutBW = ((OutW + 7) / 8) * 8;

endpackage

>>> sv/wsp_store.sv
// ----------------------------------------------------------------------------
// wsp_store
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wsp_store (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [wsp_pkg::IdxW-1:0] i_waddr,
    input  wsp_pkg::t_entry        i_wdata,
    input  logic [wsp_pkg::IdxW-1:0] i_raddr,
    output wsp_pkg::t_entry        o_rdata
);
    import wsp_pkg::*;

    t_entry r_mem [TableDepth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/wlan_station_pair_table_unit.sv
// ----------------------------------------------------------------------------
// wlan_station_pair_table_unit
// Station/BSSID pair table: lookup, append, oldest replacement, read, clear.
// ----------------------------------------------------------------------------
// Flow: an accepted frame walks the valid entries for a match; when the table is
//   full and no match is found, a second walk over all entries finds the oldest.
//   Reads, clears and rejected frames skip both walks.
// Throughput: one item at a time; the next accept comes only after the result
//   is taken.
// Reset: synchronous, active low; the entry count clears, the memory does not.
// ----------------------------------------------------------------------------
module wlan_station_pair_table_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // func, frame_is_data, frame_len, flags_byte, addr_one, addr_two,
    // signal_dbm, radio_channel, now_ms, read_index
    input  logic [wsp_pkg::InBW-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status, entry_index, entry_count, station_addr, ap_addr, entry_signal,
    // entry_channel, entry_last_seen, entry_frames
    output logic [wsp_pkg::OutBW-1:0] m_axis_tdata
);
    import wsp_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0] r_count;
    logic [IdxW:0]   r_idx;
    logic [IdxW-1:0] r_slot;
    logic [31:0]     r_best;
    logic            r_found;
    logic [47:0]     r_sta, r_ap;
    logic [7:0]      r_sig;
    logic [3:0]      r_chan;
    logic [31:0]     r_now;
    logic [3:0]      r_status;
    logic [OutBW-1:0] r_out;
    logic            r_first;

    logic [1:0]  in_func;
    logic        in_data;
    logic [11:0] in_len;
    logic [7:0]  in_flags;
    logic [47:0] in_a1, in_a2;
    logic [7:0]  in_sig;
    logic [3:0]  in_chan;
    logic [31:0] in_now;
    logic [5:0]  in_ridx;

    assign in_func  = s_axis_tdata[1:0];
    assign in_data  = s_axis_tdata[2];
    assign in_len   = s_axis_tdata[14:3];
    assign in_flags = s_axis_tdata[22:15];
    assign in_a1    = s_axis_tdata[70:23];
    assign in_a2    = s_axis_tdata[118:71];
    assign in_sig   = s_axis_tdata[126:119];
    assign in_chan  = s_axis_tdata[130:127];
    assign in_now   = s_axis_tdata[162:131];
    assign in_ridx  = s_axis_tdata[168:163];

    logic            we;
    logic [IdxW-1:0] raddr;
    t_entry          wdata, rdata;
    // read data tag: index of the entry that rdata holds
    logic [IdxW:0]   r_ridx;
    logic            r_rvalid;

    wsp_store u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_slot),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic to_ds, from_ds;
    logic [47:0] sta_sel, ap_sel;
    assign to_ds   = in_flags[0];
    assign from_ds = in_flags[1];
    assign ap_sel  = to_ds ? in_a1 : in_a2;
    assign sta_sel = to_ds ? in_a2 : in_a1;

    logic in_rd_oor, in_obs_ok;
    logic scan_hit, scan_end, tbl_full, old_end;
    assign in_rd_oor = (7'(in_ridx) >= 7'(r_count));
    assign in_obs_ok = (in_func == FN_OBSERVE) && in_data && !(in_len < MinHeaderLen)
                       && (to_ds != from_ds) && !sta_sel[GroupBit] && (sta_sel != ap_sel);
    assign scan_hit  = r_rvalid && rdata.sta == r_sta && rdata.ap == r_ap;
    assign scan_end  = !r_rvalid || (CntW'(r_ridx) + 1'b1 >= r_count);
    assign tbl_full  = (r_count >= CntW'(TableDepth));
    assign old_end   = (r_ridx == (IdxW+1)'(TableDepth - 1));

    function automatic logic [OutBW-1:0] pack_out(logic [3:0] st, logic [5:0] ix,
                                                  logic [6:0] cnt, t_entry e);
        pack_out = OutBW'({e.frames, e.seen, e.chan, e.sig, e.ap, e.sta, cnt, ix, st});
    endfunction

    always_comb begin
        raddr = r_idx[IdxW-1:0];
        if (r_state == S_IDLE) begin
            raddr = (in_func == FN_READ) ? in_ridx[IdxW-1:0] : '0;
        end
    end

    // write entry: a new pair starts its frame count at one
    always_comb begin
        wdata.sta    = r_sta;
        wdata.ap     = r_ap;
        wdata.sig    = r_sig;
        wdata.chan   = r_chan;
        wdata.seen   = r_now;
        wdata.frames = r_found ? rdata.frames + 32'd1 : 32'd1;
    end
    assign we = (r_state == S_WRITE) && !r_first;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_func == FN_READ) begin
                        n_state = in_rd_oor ? S_OUT : S_READ;
                    end else if (in_obs_ok) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_WRITE;
                end else if (scan_end) begin
                    n_state = tbl_full ? S_OLD : S_WRITE;
                end
            end
            S_OLD:   if (old_end) n_state = S_WRITE;
            S_WRITE: if (!r_first) n_state = S_OUT;
            S_READ:  n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (accept) begin
                    r_sta <= sta_sel; r_ap <= ap_sel;
                    r_sig <= in_sig; r_chan <= in_chan; r_now <= in_now;
                    r_found <= 1'b0; r_first <= 1'b1;
                    r_slot <= in_ridx[IdxW-1:0];
                    if (in_func == FN_READ) begin
                        if (in_rd_oor) begin
                            r_out <= pack_out(ST_READ_OOR, '0, 7'(r_count), '0);
                        end
                    end else if (in_func == FN_CLEAR) begin
                        r_count <= '0;
                        r_out <= pack_out(ST_CLEARED, '0, 7'd0, '0);
                    end else if (in_func != FN_OBSERVE || !in_data
                                 || in_len < MinHeaderLen) begin
                        r_out <= pack_out(ST_NOT_DATA, '0, 7'(r_count), '0);
                    end else if (to_ds == from_ds) begin
                        r_out <= pack_out(ST_BAD_DS, '0, 7'(r_count), '0);
                    end else if (sta_sel[GroupBit] || sta_sel == ap_sel) begin
                        r_out <= pack_out(ST_DROPPED, '0, 7'(r_count), '0);
                    end else begin
                        r_idx <= (IdxW+1)'(1);
                        r_rvalid <= (r_count != '0);
                        r_ridx <= '0;
                    end
                end
                S_READ: begin
                    r_out <= pack_out(ST_READ_OK, 6'(r_slot), 7'(r_count), rdata);
                end
                S_SCAN: begin
                    // rdata holds entry r_ridx when r_rvalid
                    if (scan_hit) begin
                        r_found  <= 1'b1;
                        r_slot   <= r_ridx[IdxW-1:0];
                        r_status <= ST_UPDATED;
                        r_idx    <= r_ridx;
                    end else if (scan_end) begin
                        if (tbl_full) begin
                            r_idx <= (IdxW+1)'(1);
                            r_rvalid <= 1'b1; r_ridx <= '0;
                        end else begin
                            r_slot <= r_count[IdxW-1:0];
                            r_count <= r_count + 1'b1;
                            r_status <= ST_APPENDED;
                        end
                    end else begin
                        r_ridx <= r_idx;
                        r_idx  <= r_idx + 1'b1;
                    end
                    r_first <= 1'b1;
                end
                S_OLD: begin
                    if (r_ridx == '0 || rdata.seen < r_best) begin
                        r_best <= rdata.seen;
                        r_slot <= r_ridx[IdxW-1:0];
                    end
                    if (old_end) begin
                        r_status <= ST_REPLACED;
                    end else begin
                        r_ridx <= r_idx;
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                S_WRITE: begin
                    // while r_first is set the slot is re-read; then the entry is written
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_idx   <= {1'b0, r_slot};
                    end else begin
                        r_out <= pack_out(r_status, 6'(r_slot), 7'(r_count), wdata);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> sv/wsp_checker.sv
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks for the pair table.
// ----------------------------------------------------------------------------
module wsp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [wsp_pkg::OutBW-1:0] m_axis_tdata
);
    import wsp_pkg::*;

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept not held");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:10] <= 7'(TableDepth))
        else $error("count too big");

endmodule

bind wlan_station_pair_table_unit wsp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

>>> dv/tb_wlan_station_pair_table_unit.sv
// ----------------------------------------------------------------------------
// tb_wlan_station_pair_table_unit
// Stream testbench for the station/BSSID pair table. A behavioural copy of
// the table predicts each response; each response is compared whole
// against a queue of predicted responses, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_wlan_station_pair_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import wsp_pkg::*;

    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic [31:0] frames;
        logic [31:0] seen;
        logic [3:0]  chan;
        logic [7:0]  sig;
        logic [47:0] ap;
        logic [47:0] sta;
        logic [6:0]  count;
        logic [5:0]  idx;
        logic [3:0]  status;
    } t_resp;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [InBW-1:0]    s_axis_tdata;   // func, is_data, len, flags, addr1, addr2, sig, chan, now, idx
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OutBW-1:0]   m_axis_tdata;   // status, idx, count, sta, ap, sig, chan, seen, frames

    wlan_station_pair_table_unit DUT (.*);

    // predicted table contents
    logic [47:0] tbl_sta [TableDepth];
    logic [47:0] tbl_ap  [TableDepth];
    logic [7:0]  tbl_sig [TableDepth];
    logic [3:0]  tbl_chan[TableDepth];
    logic [31:0] tbl_seen[TableDepth];
    logic [31:0] tbl_frm [TableDepth];
    int          tbl_count;

    t_resp       pending_resp[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;
    bit          hold_off;
    int          now_clock;
    logic [47:0] known_sta[$];
    logic [47:0] known_ap[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_resp plain_resp(logic [3:0] st);
        t_resp r;
        r = '0;
        r.status = st;
        r.count = 7'(tbl_count);
        return r;
    endfunction

    function automatic t_resp entry_resp(logic [3:0] st, int s);
        t_resp r;
        r.status = st;
        r.idx = 6'(s);
        r.count = 7'(tbl_count);
        r.sta = tbl_sta[s];
        r.ap = tbl_ap[s];
        r.sig = tbl_sig[s];
        r.chan = tbl_chan[s];
        r.seen = tbl_seen[s];
        r.frames = tbl_frm[s];
        return r;
    endfunction

    function automatic t_resp predict_table(t_func fn, logic dat, logic [11:0] len,
                                            logic [7:0] flags, logic [47:0] a1,
                                            logic [47:0] a2, logic [7:0] sig,
                                            logic [3:0] chan, logic [31:0] now,
                                            logic [5:0] ridx);
        logic [47:0] sta, bss;
        int s;
        bit found;
        logic [3:0] st;
        found = 0;
        s = 0;
        case (fn)
            FN_READ: begin
                if (ridx >= tbl_count) return plain_resp(ST_READ_OOR);
                return entry_resp(ST_READ_OK, ridx);
            end
            FN_CLEAR: begin
                tbl_count = 0;
                return plain_resp(ST_CLEARED);
            end
            FN_NONE: return plain_resp(ST_NOT_DATA);
            default: ;
        endcase
        if (!dat || len < MinHeaderLen) return plain_resp(ST_NOT_DATA);
        if (flags[0] == flags[1]) return plain_resp(ST_BAD_DS);
        bss = flags[0] ? a1 : a2;
        sta = flags[0] ? a2 : a1;
        if (sta[GroupBit] || sta == bss) return plain_resp(ST_DROPPED);
        for (int i = 0; i < tbl_count; i++) begin
            if (!found && tbl_sta[i] == sta && tbl_ap[i] == bss) begin
                s = i;
                found = 1;
            end
        end
        if (found) begin
            st = ST_UPDATED;
        end else begin
            if (tbl_count >= TableDepth) begin
                s = 0;
                for (int i = 1; i < TableDepth; i++)
                    if (tbl_seen[i] < tbl_seen[s]) s = i;
                st = ST_REPLACED;
            end else begin
                s = tbl_count;
                tbl_count++;
                st = ST_APPENDED;
            end
            tbl_sta[s] = sta;
            tbl_ap[s] = bss;
            tbl_frm[s] = 0;
        end
        tbl_sig[s] = sig;
        tbl_chan[s] = chan;
        tbl_seen[s] = now;
        tbl_frm[s] = tbl_frm[s] + 1;
        return entry_resp(st, s);
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_frame(t_func fn, logic dat, logic [11:0] len, logic [7:0] flags,
                              logic [47:0] a1, logic [47:0] a2, logic [7:0] sig,
                              logic [3:0] chan, logic [31:0] now, logic [5:0] ridx,
                              bit gaps = 1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tdata <= InBW'({ridx, now, chan, sig, a2, a1, flags, len, dat, fn});
        s_axis_tvalid <= 1'b1;
        pending_resp.push_back(predict_table(fn, dat, len, flags, a1, a2, sig, chan, now,
                                             ridx));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // well-formed frame for a pair, to-DS or from-DS chosen at random
    task automatic send_pair(logic [47:0] sta, logic [47:0] ap, logic [31:0] now,
                             bit gaps = 1);
        bit to_ds;
        to_ds = 1'($urandom_range(0, 1));
        send_frame(FN_OBSERVE, 1'b1, 12'($urandom_range(24, 4095)),
                   {6'($urandom_range(0, 63)), ~to_ds, to_ds}, to_ds ? ap : sta,
                   to_ds ? sta : ap, 8'($urandom), 4'($urandom_range(1, 14)), now, '0, gaps);
    endtask

    function automatic logic [47:0] rand_addr();
        logic [47:0] a;
        a = 48'({$urandom, $urandom});
        a[GroupBit] = 1'b0;
        return a;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [47:0] s1, a1;
        s1 = 48'h0000_0000_0002;
        a1 = 48'hFEFF_FFFF_FFFF;
        send_frame(FN_READ, 0, 0, 0, '0, '0, 0, 1, 0, 0);
        send_frame(FN_OBSERVE, 0, 12'd4095, 8'h01, a1, s1, 0, 1, 0, 0);
        send_frame(FN_OBSERVE, 1, 12'd23, 8'h01, a1, s1, 0, 1, 0, 0);
        send_frame(FN_OBSERVE, 1, 12'd24, 8'h00, a1, s1, 0, 1, 0, 0);
        send_frame(FN_OBSERVE, 1, 12'd24, 8'hFF, a1, s1, 0, 1, 0, 0);
        send_frame(FN_OBSERVE, 1, 12'd24, 8'h01, a1, 48'h0100_0000_0000, 0, 1, 0, 0);
        send_frame(FN_OBSERVE, 1, 12'd24, 8'h02, a1, a1, 0, 1, 0, 0);
        send_frame(FN_OBSERVE, 1, 12'd24, 8'hFD, a1, s1, 8'h80, 4'd1, 32'hFFFF_FFFF, 0);
        send_frame(FN_OBSERVE, 1, 12'd4095, 8'h01, a1, s1, 8'h7F, 4'd14, 32'h0, 0);
        send_frame(FN_OBSERVE, 1, 12'd100, 8'h02, s1, a1, 8'hFF, 4'd7, 32'h5, 0);
        send_frame(FN_OBSERVE, 1, 12'd100, 8'hFE, 48'hFFFF_FFFF_FFFE, 48'h0, 8'h01,
                   4'd3, 32'hAAAA_5555, 0);
        send_frame(FN_READ, 0, 0, 0, '0, '0, 0, 1, 0, 6'd0);
        send_frame(FN_READ, 1, 12'hFFF, 8'hFF, '1, '1, 8'hFF, 4'd14, '1, 6'd2);
        send_frame(FN_READ, 0, 0, 0, '0, '0, 0, 1, 0, 6'd63);
        send_frame(FN_NONE, 1, 12'hFFF, 8'h01, a1, s1, 0, 1, 0, 6'd1);
        send_frame(FN_CLEAR, 0, 0, 0, '0, '0, 0, 1, 0, 0);
        send_frame(FN_READ, 0, 0, 0, '0, '0, 0, 1, 0, 6'd0);
        drain();
    endtask

    // fill past depth so replacement kicks in, including time ties
    task automatic test_fill_replace();
        logic [47:0] sta, ap;
        known_sta.delete();
        known_ap.delete();
        send_frame(FN_CLEAR, 0, 0, 0, '0, '0, 0, 1, 0, 0);
        for (int i = 0; i < TableDepth + 20; i++) begin
            sta = rand_addr();
            ap = rand_addr();
            known_sta.push_back(sta);
            known_ap.push_back(ap);
            send_pair(sta, ap, (i % 3 == 0) ? 32'd7 : $urandom);
        end
        for (int i = 0; i < 6; i++)
            send_frame(FN_READ, 0, 0, 0, '0, '0, 0, 1, 0, 6'($urandom_range(0, 63)));
        drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 10; i++)
                send_pair(known_sta[i % known_sta.size()], known_ap[i % known_ap.size()],
                          $urandom, 0);
        join
        drain();
    endtask

    task automatic test_random(int n);
        int p, k;
        logic [47:0] sta, ap;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            now_clock += $urandom_range(0, 50);
            if (p < 55 && known_sta.size() != 0) begin
                k = $urandom_range(0, known_sta.size() - 1);
                send_pair(known_sta[k], known_ap[k], now_clock);
            end else if (p < 70) begin
                sta = rand_addr();
                ap = rand_addr();
                if (known_sta.size() < 100) begin
                    known_sta.push_back(sta);
                    known_ap.push_back(ap);
                end
                send_pair(sta, ap, ($urandom_range(0, 9) == 0) ? $urandom : now_clock);
            end else if (p < 82) begin
                send_frame(FN_READ, 1'($urandom_range(0, 1)), 12'($urandom), 8'($urandom),
                           48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                           8'($urandom), 4'($urandom_range(1, 14)), $urandom,
                           6'($urandom));
            end else if (p < 84) begin
                send_frame(FN_CLEAR, 0, 0, 0, '0, '0, 0, 1, 0, 0);
            end else if (p < 86) begin
                send_frame(FN_NONE, 1, 12'($urandom), 8'($urandom),
                           48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                           8'($urandom), 4'($urandom_range(1, 14)), $urandom,
                           6'($urandom));
            end else begin
                send_frame(FN_OBSERVE, 1'($urandom_range(0, 1)), 12'($urandom),
                           8'($urandom), 48'({$urandom, $urandom}),
                           48'({$urandom, $urandom}), 8'($urandom),
                           4'($urandom_range(1, 14)), $urandom, 6'($urandom));
            end
        end
        drain();
    endtask

    // receiver stalls
    initial begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (g > 0) begin
                m_axis_tready <= 1'b0;
                g--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) g = gap_len();
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_resp got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_resp'(m_axis_tdata[$bits(t_resp)-1:0]);
            if (pending_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h", got);
            end else begin
                exp_r = pending_resp.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: st %0d/%0d idx %0d/%0d cnt %0d/%0d",
                                 exp_r.status, got.status, exp_r.idx, got.idx,
                                 exp_r.count, got.count,
                                 " sta %h/%h ap %h/%h sig %h/%h",
                                 exp_r.sta, got.sta, exp_r.ap, got.ap,
                                 exp_r.sig, got.sig,
                                 " ch %0d/%0d seen %h/%h frm %0d/%0d",
                                 exp_r.chan, got.chan, exp_r.seen, got.seen,
                                 exp_r.frames, got.frames);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit && !timed_out) begin
            timed_out <= 1'b1;
            $display("wlan_station_pair_table_unit test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        hold_off = 1'b0;
        tbl_count = 0;
        now_clock = 1000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_replace();
        test_backpressure();
        test_random(1000);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_resp.size() == 0)
            $display("wlan_station_pair_table_unit test passed");
        else
            $display("wlan_station_pair_table_unit test failed");
        $finish;
    end

endmodule
